/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the block.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csps check failed");

// Consequent checked in the cycle after the antecedent.
`define CSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csps check failed");

`endif

/* rtl/csps_pkg.sv */
// Package for the clock synthesiser parameter search: widths, tables, item types
// and the candidate list. No dependencies.
`timescale 1ns / 1ps

package csps_pkg;

    // search space
    localparam int D_MAX        = 10;
    localparam int FB_MAX       = 64;
    localparam int FB_MIN_PER_D = 6;
    localparam int FB_MAX_PER_D = 12;
    localparam int DIV_MAX      = 128;

    localparam longint unsigned REF_HZ = 64'd100000000;

    // datapath widths
    localparam int F5W   = 31;  // 5x target frequency
    localparam int DEN_W = 34;  // D * F
    localparam int R1W   = 35;  // rounding division remainder
    localparam int Q1W   = 28;  // output divider quotient
    localparam int R2W   = 33;  // REF * M
    localparam int DV2W  = 32;  // D * O
    localparam int Q2W   = 31;  // achieved frequency quotient
    localparam int ERR_W = 31;

    localparam logic [ERR_W-1:0] START_ERR = 31'd2000000000;

    // entry stage + divider steps + multiply stage
    localparam int CELL_LAT = Q1W + Q2W + 2;

    // x / 5 == (x * RECIP5) >> RECIP5_SH for any 32-bit x
    localparam logic [31:0] RECIP5    = 32'hCCCCCCCD;
    localparam int          RECIP5_SH = 34;

    localparam logic [19:0] LOCK_LO20    = 20'hFA401;
    localparam logic [13:0] DIV_ONE_WORD = 14'h1041;

    // upper 20 bits of the lock entries, indexed by M-1
    localparam logic [19:0] LOCK_HI [64] = '{
        20'h31BE8, 20'h31BE8, 20'h423E8, 20'h5AFE8, 20'h73BE8, 20'h8C7E8, 20'h9CFE8, 20'hB5BE8,
        20'hCE7E8, 20'hE73E8, 20'hFFF84, 20'hFFF39, 20'hFFEEE, 20'hFFEBC, 20'hFFE8A, 20'hFFE71,
        20'hFFE3F, 20'hFFE26, 20'hFFE0D, 20'hFFDF4, 20'hFFDDB, 20'hFFDDB, 20'hFFDC2, 20'hFFDA9,
        20'hFFD90, 20'hFFD90, 20'hFFD77, 20'hFFD77, 20'hFFD5E, 20'hFFD5E, 20'hFFD45, 20'hFFD45,
        20'hFFD2C, 20'hFFD2C, 20'hFFD2C, 20'hFFD13, 20'hFFD13, 20'hFFD13, 20'hFFCFA, 20'hFFCFA,
        20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA,
        20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA,
        20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA, 20'hFFCFA
    };

    // loop filter entries, indexed by M-1
    localparam logic [9:0] FILT_TAB [64] = '{
        10'h05F, 10'h057, 10'h07B, 10'h05B, 10'h06B, 10'h073, 10'h073, 10'h073,
        10'h073, 10'h04B, 10'h04B, 10'h04B, 10'h0B3, 10'h053, 10'h053, 10'h053,
        10'h053, 10'h053, 10'h053, 10'h053, 10'h053, 10'h053, 10'h053, 10'h063,
        10'h063, 10'h063, 10'h063, 10'h063, 10'h063, 10'h063, 10'h063, 10'h063,
        10'h063, 10'h063, 10'h063, 10'h063, 10'h063, 10'h093, 10'h093, 10'h093,
        10'h093, 10'h093, 10'h093, 10'h093, 10'h093, 10'h093, 10'h093, 10'h0A3,
        10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3,
        10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3, 10'h0A3
    };

    typedef struct packed {
        logic [27:0] pixel_freq_hz;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [3:0]  main_div;
        logic [6:0]  fb_mult;
        logic [7:0]  out_div;
        logic [27:0] achieved_freq_hz;
        logic [28:0] error_hz;
        logic [23:0] clk_out_word;
        logic [23:0] fb_word;
        logic [13:0] div_word;
        logic [31:0] lock_low;
        logic [25:0] filter_lock_high;
    } out_item_t;

    // running best, handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [F5W-1:0]   f5;
        logic [ERR_W-1:0] err;
        logic [Q2W-1:0]   freq;
        logic [3:0]       d;
        logic [6:0]       m;
        logic [Q1W-1:0]   o;
        logic             found;
    } best_t;

    // highest feedback multiplier for a given input divider
    function automatic int fb_hi(input int d);
        int hi;
        hi = d * FB_MAX_PER_D;
        if (hi > FB_MAX)
            hi = FB_MAX;
        return hi;
    endfunction

    function automatic int cand_count();
        int c;
        c = 0;
        for (int d = 1; d <= D_MAX; d++)
            c += fb_hi(d) - d * FB_MIN_PER_D + 1;
        return c;
    endfunction

    // input divider of the k-th candidate, D outer and M inner
    function automatic int cand_d(input int k);
        int c;
        int dd;
        c  = 0;
        dd = 0;
        for (int d = 1; d <= D_MAX; d++)
            for (int m = d * FB_MIN_PER_D; m <= fb_hi(d); m++)
            begin
                if (c == k)
                    dd = d;
                c++;
            end
        return dd;
    endfunction

    function automatic int cand_m(input int k);
        int c;
        int mm;
        c  = 0;
        mm = 0;
        for (int d = 1; d <= D_MAX; d++)
            for (int m = d * FB_MIN_PER_D; m <= fb_hi(d); m++)
            begin
                if (c == k)
                    mm = m;
                c++;
            end
        return mm;
    endfunction

    localparam int NUM_CANDS = cand_count();

    // high/low divider word; a divide by one sets the no-count bit
    function automatic logic [13:0] div_encode(input logic [7:0] n);
        logic [7:0]  h;
        logic [7:0]  l;
        logic [13:0] w;
        h = n >> 1;
        l = n - h;
        if (n == 8'd1)
            w = DIV_ONE_WORD;
        else
            w = {n[0], 1'b0, h[5:0], l[5:0]};
        return w;
    endfunction

    function automatic logic [23:0] count_encode(input logic [7:0] n);
        logic [13:0] w;
        w = div_encode(n);
        return {w[13:12], 10'd0, w[11:0]};
    endfunction

endpackage

/* rtl/csps_stream_if.sv */
// Valid/ready stream interface used for the item channels.
// Payload type given per instance; no package dependency.
`timescale 1ns / 1ps

interface csps_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/csps_div_step.sv */
// One registered restoring division step: one quotient bit per stage.
// No dependencies.
`timescale 1ns / 1ps

module csps_div_step #(
    parameter int RW = 35,
    parameter int DW = 35,
    parameter int QW = 28,
    parameter int SH = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] r_in,
    input  logic [DW-1:0] dv_in,
    input  logic [QW-1:0] q_in,
    output logic [RW-1:0] r_out,
    output logic [DW-1:0] dv_out,
    output logic [QW-1:0] q_out
);

    logic [RW-1:0] dv_ext;
    logic          ge;
    logic [RW-1:0] r_next;
    logic [QW-1:0] q_next;
    logic [RW-1:0] r_reg;
    logic [DW-1:0] dv_reg;
    logic [QW-1:0] q_reg;

    // trial subtract of the divisor at this bit position
    assign dv_ext = RW'(dv_in);
    assign ge     = (r_in >> SH) >= dv_ext;
    assign r_next = ge ? r_in - (dv_ext << SH) : r_in;
    assign q_next = {q_in[QW-2:0], ge};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg  <= r_next;
            dv_reg <= dv_in;
            q_reg  <= q_next;
        end
    end

    assign r_out  = r_reg;
    assign dv_out = dv_reg;
    assign q_out  = q_reg;

endmodule

/* rtl/csps_cand_cell.sv */
// One candidate cell of the search chain: a divider pair D, M, its own
// division pipeline and the compare stage of the running best. Uses csps_pkg.
`timescale 1ns / 1ps

module csps_cand_cell #(
    parameter int D_VAL = 1,
    parameter int M_VAL = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [csps_pkg::F5W-1:0] f_in,
    output logic [csps_pkg::F5W-1:0] f_out,
    input  csps_pkg::best_t          best_in,
    output csps_pkg::best_t          best_out
);
    import csps_pkg::*;

    localparam logic [R2W-1:0] NUM_C = R2W'(REF_HZ * 64'(M_VAL));

    logic [F5W-1:0]   f_reg;
    logic [DEN_W-1:0] den;
    logic [R1W-1:0]   n1_next;
    logic [R1W-1:0]   dv1_next;
    logic [R1W-1:0]   n1_reg;
    logic [R1W-1:0]   dv1_reg;

    logic [R1W-1:0]   r1_s  [Q1W+1];
    logic [R1W-1:0]   dv1_s [Q1W+1];
    logic [Q1W-1:0]   q1_s  [Q1W+1];

    logic [Q1W-1:0]   o_mul;
    logic [DV2W-1:0]  dv2_next;
    logic [DV2W-1:0]  dv2_reg;
    logic [Q1W-1:0]   o_pipe_reg [Q2W+1];

    logic [R2W-1:0]   r2_s  [Q2W+1];
    logic [DV2W-1:0]  dv2_s [Q2W+1];
    logic [Q2W-1:0]   q2_s  [Q2W+1];

    logic [Q2W-1:0]   a_val;
    logic [Q1W-1:0]   o_fin;
    logic [ERR_W-1:0] diff;
    logic             take;
    best_t            best_next;
    best_t            best_pl_reg;
    logic             valid_reg;

    // frequency chain towards the next cell
    always_ff @(posedge clk)
    begin
        if (en)
            f_reg <= f_in;
    end
    assign f_out = f_reg;

    // entry: O = floor((2*REF*M + D*F) / (2*D*F))
    assign den      = DEN_W'(f_in) * DEN_W'(D_VAL);
    assign n1_next  = R1W'({NUM_C, 1'b0}) + R1W'(den);
    assign dv1_next = R1W'({den, 1'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= n1_next;
            dv1_reg <= dv1_next;
        end
    end

    assign r1_s[0]  = n1_reg;
    assign dv1_s[0] = dv1_reg;
    assign q1_s[0]  = '0;

    for (genvar j = 0; j < Q1W; j++)
    begin : g_div1
        csps_div_step #(
            .RW(R1W), .DW(R1W), .QW(Q1W), .SH(Q1W - 1 - j)
        ) u_step (
            .clk    (clk),
            .en     (en),
            .r_in   (r1_s[j]),
            .dv_in  (dv1_s[j]),
            .q_in   (q1_s[j]),
            .r_out  (r1_s[j+1]),
            .dv_out (dv1_s[j+1]),
            .q_out  (q1_s[j+1])
        );
    end

    // D * O for the achieved frequency division
    assign o_mul    = q1_s[Q1W];
    assign dv2_next = DV2W'(o_mul) * DV2W'(D_VAL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv2_reg       <= dv2_next;
            o_pipe_reg[0] <= o_mul;
            for (int j = 0; j < Q2W; j++)
                o_pipe_reg[j+1] <= o_pipe_reg[j];
        end
    end

    // A = floor(REF*M / (D*O))
    assign r2_s[0]  = NUM_C;
    assign dv2_s[0] = dv2_reg;
    assign q2_s[0]  = '0;

    for (genvar j = 0; j < Q2W; j++)
    begin : g_div2
        csps_div_step #(
            .RW(R2W), .DW(DV2W), .QW(Q2W), .SH(Q2W - 1 - j)
        ) u_step (
            .clk    (clk),
            .en     (en),
            .r_in   (r2_s[j]),
            .dv_in  (dv2_s[j]),
            .q_in   (q2_s[j]),
            .r_out  (r2_s[j+1]),
            .dv_out (dv2_s[j+1]),
            .q_out  (q2_s[j+1])
        );
    end

    // compare against the running best; ties keep the earlier pair
    assign a_val = q2_s[Q2W];
    assign o_fin = o_pipe_reg[Q2W];
    assign diff  = (a_val >= best_in.f5) ? a_val - best_in.f5 : best_in.f5 - a_val;
    assign take  = (best_in.f5 != '0) && (o_fin != '0) && (diff < best_in.err);

    always_comb
    begin
        best_next = best_in;
        if (take)
        begin
            best_next.err   = diff;
            best_next.freq  = a_val;
            best_next.d     = 4'(D_VAL);
            best_next.m     = 7'(M_VAL);
            best_next.o     = o_fin;
            best_next.found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= best_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            best_pl_reg <= best_next;
    end

    always_comb
    begin
        best_out       = best_pl_reg;
        best_out.valid = valid_reg;
    end

endmodule

/* rtl/csps_encode.sv */
// Result encoding: divide by five, divider/count words, lock and filter
// lookups, and the output register. Uses csps_pkg.
`timescale 1ns / 1ps

module csps_encode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  csps_pkg::best_t     best_in,
    output csps_pkg::out_item_t item_out,
    output logic                valid_out
);
    import csps_pkg::*;

    logic        ok;
    logic [5:0]  idx;
    logic [19:0] lock_hi;
    logic [31:0] err32;
    logic [31:0] freq32;
    logic [63:0] err_prod_next;
    logic [63:0] freq_prod_next;
    logic [23:0] clk_word_next;
    logic [23:0] fb_word_next;
    logic [13:0] div_word_next;
    logic [31:0] lock_low_next;
    logic [25:0] flh_next;

    logic        e1_valid_reg;
    logic        ok_reg;
    logic [3:0]  d_reg;
    logic [6:0]  m_reg;
    logic [7:0]  o_reg;
    logic [63:0] err_prod_reg;
    logic [63:0] freq_prod_reg;
    logic [23:0] clk_word_reg;
    logic [23:0] fb_word_reg;
    logic [13:0] div_word_reg;
    logic [31:0] lock_low_reg;
    logic [25:0] flh_reg;

    logic        out_valid_reg;
    out_item_t   out_item_next;
    out_item_t   out_item_reg;

    // result is usable only when the output divider fits
    assign ok      = best_in.found && (best_in.o != '0) && (best_in.o <= Q1W'(DIV_MAX));
    assign idx     = 6'(best_in.m - 7'd1);
    assign lock_hi = LOCK_HI[idx];

    assign err32          = 32'(best_in.err);
    assign freq32         = 32'(best_in.freq);
    assign err_prod_next  = err32 * RECIP5;
    assign freq_prod_next = freq32 * RECIP5;

    always_comb
    begin
        clk_word_next = '0;
        fb_word_next  = '0;
        div_word_next = '0;
        lock_low_next = '0;
        flh_next      = '0;
        if (ok)
        begin
            clk_word_next = count_encode(best_in.o[7:0]);
            fb_word_next  = count_encode({1'b0, best_in.m});
            div_word_next = div_encode({4'd0, best_in.d});
            lock_low_next = {lock_hi[11:0], LOCK_LO20};
            flh_next      = {FILT_TAB[idx], 8'd0, lock_hi[19:12]};
        end
    end

    // stage one: products and table words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_valid_reg <= 1'b0;
        else if (en)
            e1_valid_reg <= best_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg        <= ok;
            d_reg         <= best_in.d;
            m_reg         <= best_in.m;
            o_reg         <= best_in.o[7:0];
            err_prod_reg  <= err_prod_next;
            freq_prod_reg <= freq_prod_next;
            clk_word_reg  <= clk_word_next;
            fb_word_reg   <= fb_word_next;
            div_word_reg  <= div_word_next;
            lock_low_reg  <= lock_low_next;
            flh_reg       <= flh_next;
        end
    end

    // stage two: output register
    always_comb
    begin
        out_item_next.valid_res        = ok_reg;
        out_item_next.main_div         = d_reg;
        out_item_next.fb_mult          = m_reg;
        out_item_next.out_div          = o_reg;
        out_item_next.achieved_freq_hz = 28'(freq_prod_reg >> RECIP5_SH);
        out_item_next.error_hz         = 29'(err_prod_reg >> RECIP5_SH);
        out_item_next.clk_out_word     = clk_word_reg;
        out_item_next.fb_word          = fb_word_reg;
        out_item_next.div_word         = div_word_reg;
        out_item_next.lock_low         = lock_low_reg;
        out_item_next.filter_lock_high = flh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= e1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign valid_out = out_valid_reg;
    assign item_out  = out_item_reg;

endmodule

/* rtl/clock_synth_param_search_core.sv */
// Clock synthesiser parameter search. Takes one target pixel frequency per clock while the
// output is not stalled, and returns the input divider, feedback multiplier and output
// divider with the smallest error, plus the packed divider, lock and filter words. The
// search runs down a chain of 180 candidate cells, one per divider pair; each cell has
// its own 28-step and 31-step restoring dividers. A new item is taken every cycle while
// no result waits on the output; the whole pipeline holds while a result waits on the
// output with ready low.
`timescale 1ns / 1ps

module clock_synth_param_search_core (
    input  logic          clk,
    input  logic          rst_n,
    csps_stream_if.sink   req,
    csps_stream_if.source res
);
    import csps_pkg::*;

    logic           en;
    logic [F5W-1:0] f5_next;
    logic [F5W-1:0] f_head_reg;
    logic           head_valid_reg;
    logic           hd_valid_reg [CELL_LAT];
    logic [F5W-1:0] hd_f_reg     [CELL_LAT];
    logic [F5W-1:0] f_chain      [NUM_CANDS+1];
    best_t          best_chain   [NUM_CANDS+1];

    // whole pipeline advances unless a result is stuck at the output
    assign en        = !res.valid || res.ready;
    assign req.ready = en;

    // F = 5 * f
    assign f5_next = F5W'({req.payload.pixel_freq_hz, 2'b00}) + F5W'(req.payload.pixel_freq_hz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_valid_reg <= 1'b0;
        else if (en)
            head_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_head_reg <= f5_next;
    end

    // delay line aligning the running best with the first cell's dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CELL_LAT; j++)
                hd_valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            hd_valid_reg[0] <= head_valid_reg;
            for (int j = 1; j < CELL_LAT; j++)
                hd_valid_reg[j] <= hd_valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_f_reg[0] <= f_head_reg;
            for (int j = 1; j < CELL_LAT; j++)
                hd_f_reg[j] <= hd_f_reg[j-1];
        end
    end

    // starting point of the search
    always_comb
    begin
        best_chain[0]       = '0;
        best_chain[0].valid = hd_valid_reg[CELL_LAT-1];
        best_chain[0].f5    = hd_f_reg[CELL_LAT-1];
        best_chain[0].err   = START_ERR;
    end

    assign f_chain[0] = f_head_reg;

    // candidate cells, D outer and M inner
    for (genvar k = 0; k < NUM_CANDS; k++)
    begin : g_cell
        localparam int DK = cand_d(k);
        localparam int MK = cand_m(k);

        csps_cand_cell #(
            .D_VAL(DK),
            .M_VAL(MK)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .f_in     (f_chain[k]),
            .f_out    (f_chain[k+1]),
            .best_in  (best_chain[k]),
            .best_out (best_chain[k+1])
        );
    end

    csps_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .best_in   (best_chain[NUM_CANDS]),
        .item_out  (res.payload),
        .valid_out (res.valid)
    );

endmodule

/* rtl/csps_checker.sv */
// Port-level checks for the parameter search core, bound to the top level.
// Uses csps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input csps_pkg::out_item_t out_item
);
    import csps_pkg::*;

    // a held result stays put
    `CSPS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

    // no item enters while the output is stalled
    `CSPS_ASSERT_SAME(a_stall, clk, rst_n, out_valid && !out_ready, !(in_valid && in_ready))

    // a good result carries picks inside the search range
    `CSPS_ASSERT_SAME(a_range, clk, rst_n, out_valid && out_item.valid_res, out_item.main_div != 4'd0 && out_item.main_div <= 4'(D_MAX) && out_item.fb_mult >= 7'(FB_MIN_PER_D) && out_item.fb_mult <= 7'(FB_MAX) && out_item.out_div != 8'd0 && out_item.out_div <= 8'(DIV_MAX))

    // a failed result carries no words
    `CSPS_ASSERT_SAME(a_zero, clk, rst_n, out_valid && !out_item.valid_res, out_item.clk_out_word == '0 && out_item.fb_word == '0 && out_item.div_word == '0 && out_item.lock_low == '0 && out_item.filter_lock_high == '0)

endmodule

bind clock_synth_param_search_core csps_checker u_csps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_item  (res.payload)
);
